FILE: rtl/core/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define ASSERT_PROP(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// expression that must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

FILE: rtl/core/lpps_pkg.sv
`default_nettype none

package lpps_pkg;

   localparam int PIX_W       = 8;
   localparam int ROW_WIDTH_DEF = 320;
   localparam int CENTRE      = 160;
   localparam int COUNT_W     = 10;
   localparam int SUM_W       = 18;
   localparam int ERR_W       = 10;
   localparam int ERR_MAX     = 1023;
   localparam int MINC_W      = 11;
   localparam int ACT_W       = 2;
   localparam int SPEED_W     = 9;
   localparam int SPEED_LIMIT = 160;
   localparam int BASE_SPEED  = 45;
   localparam int REV_SPEED   = 40;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 11;
   localparam logic [CSR_IDX_W-1:0] REG_THRESHOLD = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MIN_COUNT = 2'd1;
   localparam logic [PIX_W-1:0]  THRESHOLD_RESET = 8'd130;
   localparam logic [MINC_W-1:0] MIN_COUNT_RESET = 11'd20;

   localparam logic [ACT_W-1:0] ACT_NO_LINE = 2'd0;
   localparam logic [ACT_W-1:0] ACT_REVERSE = 2'd1;
   localparam logic [ACT_W-1:0] ACT_STEER   = 2'd2;
   localparam logic [ACT_W-1:0] ACT_CENTRED = 2'd3;

   // restoring divider: one quotient bit per cycle
   localparam int DIV_STEPS = SUM_W;

   // x/10 = (x*RECIP) >> 22 and x/5 = (x*RECIP) >> 21, exact for x < 699050
   localparam int MUL_W   = SUM_W + 1;
   localparam int RECIP_W = 19;
   localparam int PROD_W  = MUL_W + RECIP_W;
   localparam int RECIP   = 419431;
   localparam int SHIFT10 = 22;
   localparam int SHIFT5  = 21;
   localparam int PMAG_W  = 16;
   localparam int DMAG_W  = 17;

   typedef struct packed {
      logic accum;
      logic clear_row;
      logic load_short;
      logic div_start;
      logic mul_p;
      logic mul_d;
      logic load_steer;
   } lpps_cmd_type;

   typedef struct packed {
      logic count_zero;
      logic count_low;
      logic div_done;
      logic out_free;
   } lpps_status_type;

endpackage

`default_nettype wire

FILE: rtl/core/lpps_if.sv
`default_nettype none

interface lpps_req_if;
   import lpps_pkg::*;
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] pixel;
   logic             last_in_row;
   modport source (output valid, output pixel, output last_in_row, input ready);
   modport sink   (input valid, input pixel, input last_in_row, output ready);
endinterface

interface lpps_rsp_if;
   import lpps_pkg::*;
   logic                      valid;
   logic                      ready;
   logic [ACT_W-1:0]          action;
   logic signed [SPEED_W-1:0] left_motor_speed;
   logic signed [SPEED_W-1:0] right_motor_speed;
   modport source (output valid, output action, output left_motor_speed,
                   output right_motor_speed, input ready);
   modport sink   (input valid, input action, input left_motor_speed,
                   input right_motor_speed, output ready);
endinterface

interface lpps_csr_if;
   import lpps_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/lpps_div.sv
`default_nettype none

module lpps_div (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [lpps_pkg::SUM_W-1:0]    dividend,
   input  wire logic [lpps_pkg::COUNT_W-1:0]  divisor,
   output logic [lpps_pkg::SUM_W-1:0]         quotient,
   output logic                               done
);
   import lpps_pkg::*;

   localparam int STEP_W = $clog2(DIV_STEPS);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [SUM_W-1:0]    num_ff, num_in;
   logic [COUNT_W-1:0]  rem_ff, rem_in;
   logic [COUNT_W-1:0]  den_ff, den_in;
   logic [COUNT_W:0]    rem_shift;
   logic                fits;

   always_comb begin
      rem_shift = {rem_ff, num_ff[SUM_W-1]};
      fits      = rem_shift >= {1'b0, den_ff};
      busy_in   = busy_ff;
      done_in   = done_ff;
      step_in   = step_ff;
      num_in    = num_ff;
      rem_in    = rem_ff;
      den_in    = den_ff;
      if (start) begin
         busy_in = 1'b1;
         done_in = 1'b0;
         step_in = '0;
         num_in  = dividend;
         rem_in  = '0;
         den_in  = divisor;
      end else if (busy_ff) begin
         // remainder stays below the divisor, so the top bit drops out
         rem_in  = fits ? COUNT_W'(rem_shift - {1'b0, den_ff}) : rem_shift[COUNT_W-1:0];
         num_in  = {num_ff[SUM_W-2:0], fits};
         step_in = step_ff + STEP_W'(1);
         if (step_ff == STEP_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign quotient = num_ff;
   assign done     = done_ff;

endmodule

`default_nettype wire

FILE: rtl/core/lpps_dp.sv
`default_nettype none

module lpps_dp #(
   parameter int ROW_WIDTH = lpps_pkg::ROW_WIDTH_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire lpps_pkg::lpps_cmd_type           cmd,
   output lpps_pkg::lpps_status_type             status,
   input  wire logic [lpps_pkg::PIX_W-1:0]       pixel,
   input  wire logic                             csr_write,
   input  wire logic [lpps_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [lpps_pkg::CSR_DATA_W-1:0]  csr_data,
   input  wire logic                             rsp_ready,
   output logic                                  rsp_valid,
   output logic [lpps_pkg::ACT_W-1:0]            rsp_action,
   output logic signed [lpps_pkg::SPEED_W-1:0]   rsp_left,
   output logic signed [lpps_pkg::SPEED_W-1:0]   rsp_right
);
   import lpps_pkg::*;

   localparam int COL_W = $clog2(ROW_WIDTH);
   localparam int OFF_W = ((COL_W > 8) ? COL_W : 8) + 2;
   localparam int SPW   = 20;

   function automatic logic signed [SPEED_W-1:0] clamp_speed(input logic signed [SPW-1:0] v);
      logic signed [SPEED_W-1:0] r;
      if (v > SPW'(SPEED_LIMIT))
         r = SPEED_W'(SPEED_LIMIT);
      else if (v < -SPW'(SPEED_LIMIT))
         r = -SPEED_W'(SPEED_LIMIT);
      else
         r = v[SPEED_W-1:0];
      return r;
   endfunction

   // configuration
   logic [PIX_W-1:0]  thr_ff, thr_in;
   logic [MINC_W-1:0] minc_ff, minc_in;

   // row accumulators
   logic [COL_W-1:0]        col_ff, col_in;
   logic [COUNT_W-1:0]      count_ff, count_in;
   logic signed [SUM_W-1:0] sum_ff, sum_in;
   logic [ERR_W-1:0]        past_ff, past_in;
   logic signed [OFF_W-1:0] offset;
   logic signed [SUM_W:0]   sum_wide;
   logic                    white;

   // decision datapath
   logic [SUM_W-1:0]  sum_mag;
   logic              neg_ff, neg_in;
   logic [SUM_W-1:0]  quo;
   logic              quo_done;
   logic [SUM_W-1:0]  diff_ff, diff_in;
   logic [PMAG_W-1:0] pmag_ff, pmag_in;
   logic [DMAG_W-1:0] dmag_ff, dmag_in;
   logic [MUL_W-1:0]  mul_a;
   logic [PROD_W-1:0] prod;
   logic [SUM_W-1:0]  past_ext;

   logic signed [SPW-1:0] pm_s, d_s, base_s, left_w, right_w;

   // result register
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [ACT_W-1:0]          act_ff, act_in;
   logic signed [SPEED_W-1:0] left_ff, left_in;
   logic signed [SPEED_W-1:0] right_ff, right_in;

   always_comb begin
      thr_in  = thr_ff;
      minc_in = minc_ff;
      if (csr_write) begin
         case (csr_index)
            REG_THRESHOLD: thr_in  = csr_data[PIX_W-1:0];
            REG_MIN_COUNT: minc_in = csr_data[MINC_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      white    = pixel > thr_ff;
      offset   = $signed(OFF_W'(col_ff)) - $signed(OFF_W'(CENTRE));
      sum_wide = (SUM_W+1)'(sum_ff) + (SUM_W+1)'(offset);
      col_in   = col_ff;
      count_in = count_ff;
      sum_in   = sum_ff;
      if (cmd.accum) begin
         col_in = (col_ff == COL_W'(ROW_WIDTH - 1)) ? '0 : col_ff + COL_W'(1);
         if (white) begin
            // one small step at a time: overflow shows as a sign mismatch
            if (sum_wide[SUM_W] != sum_wide[SUM_W-1])
               sum_in = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                        : {1'b0, {(SUM_W-1){1'b1}}};
            else
               sum_in = sum_wide[SUM_W-1:0];
            if (count_ff != '1)
               count_in = count_ff + COUNT_W'(1);
         end
      end
      if (cmd.clear_row) begin
         col_in   = '0;
         count_in = '0;
         sum_in   = '0;
      end
   end

   assign sum_mag = sum_ff[SUM_W-1] ? (~sum_ff + SUM_W'(1)) : sum_ff;

   lpps_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (sum_mag),
      .divisor  (count_ff),
      .quotient (quo),
      .done     (quo_done)
   );

   // one shared multiplier: 3*|e| for p, then 3*| |e| - past | for d
   always_comb begin
      past_ext = SUM_W'(past_ff);
      mul_a    = cmd.mul_p ? (MUL_W'({quo, 1'b0}) + MUL_W'(quo))
                           : (MUL_W'({diff_ff, 1'b0}) + MUL_W'(diff_ff));
      prod     = PROD_W'(mul_a) * PROD_W'(RECIP);
      neg_in   = cmd.div_start ? sum_ff[SUM_W-1] : neg_ff;
      diff_in  = diff_ff;
      pmag_in  = pmag_ff;
      dmag_in  = dmag_ff;
      past_in  = past_ff;
      if (cmd.mul_p) begin
         pmag_in = prod[SHIFT10 +: PMAG_W];
         diff_in = (quo >= past_ext) ? quo - past_ext : past_ext - quo;
         past_in = (quo > SUM_W'(ERR_MAX)) ? '1 : quo[ERR_W-1:0];
      end
      if (cmd.mul_d)
         dmag_in = prod[SHIFT5 +: DMAG_W];
   end

   always_comb begin
      pm_s    = $signed(SPW'(pmag_ff));
      d_s     = $signed(SPW'(dmag_ff));
      base_s  = $signed(SPW'(BASE_SPEED));
      left_w  = '0;
      right_w = '0;
      if (pmag_ff != '0) begin
         if (!neg_ff) begin
            left_w  = base_s;
            right_w = (pm_s + d_s <= base_s) ? pm_s - d_s - base_s : '0;
         end else begin
            left_w  = (base_s - pm_s + d_s >= 0) ? base_s - pm_s - d_s : '0;
            right_w = -base_s;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      act_in       = act_ff;
      left_in      = left_ff;
      right_in     = right_ff;
      if (cmd.load_short) begin
         rsp_valid_in = 1'b1;
         if (count_ff == '0) begin
            act_in   = ACT_NO_LINE;
            left_in  = '0;
            right_in = '0;
         end else begin
            act_in   = ACT_REVERSE;
            left_in  = -SPEED_W'(REV_SPEED);
            right_in = SPEED_W'(REV_SPEED);
         end
      end else if (cmd.load_steer) begin
         rsp_valid_in = 1'b1;
         act_in       = (pmag_ff == '0) ? ACT_CENTRED : ACT_STEER;
         left_in      = clamp_speed(left_w);
         right_in     = clamp_speed(right_w);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff       <= THRESHOLD_RESET;
         minc_ff      <= MIN_COUNT_RESET;
         col_ff       <= '0;
         count_ff     <= '0;
         sum_ff       <= '0;
         past_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         thr_ff       <= thr_in;
         minc_ff      <= minc_in;
         col_ff       <= col_in;
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         past_ff      <= past_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff   <= neg_in;
      diff_ff  <= diff_in;
      pmag_ff  <= pmag_in;
      dmag_ff  <= dmag_in;
      act_ff   <= act_in;
      left_ff  <= left_in;
      right_ff <= right_in;
   end

   assign status.count_zero = (count_ff == '0);
   assign status.count_low  = ({1'b0, count_ff} < minc_ff);
   assign status.div_done   = quo_done;
   assign status.out_free   = !rsp_valid_ff || rsp_ready;

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_action = act_ff;
   assign rsp_left   = left_ff;
   assign rsp_right  = right_ff;

endmodule

`default_nettype wire

FILE: rtl/core/lpps_ctrl.sv
`default_nettype none

module lpps_ctrl (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   input  wire logic                       req_last,
   output logic                            req_ready,
   output lpps_pkg::lpps_cmd_type          cmd,
   input  wire lpps_pkg::lpps_status_type  status
);
   import lpps_pkg::*;

   localparam logic [2:0] S_ACCUM  = 3'd0;
   localparam logic [2:0] S_DECIDE = 3'd1;
   localparam logic [2:0] S_DIV    = 3'd2;
   localparam logic [2:0] S_MULP   = 3'd3;
   localparam logic [2:0] S_MULD   = 3'd4;
   localparam logic [2:0] S_STEER  = 3'd5;

   logic [2:0] state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_ACCUM: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accum = 1'b1;
               if (req_last)
                  state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (status.count_zero || status.count_low) begin
               // hold and reverse need no divide, wait only for the result slot
               if (status.out_free) begin
                  cmd.load_short = 1'b1;
                  cmd.clear_row  = 1'b1;
                  state_in       = S_ACCUM;
               end
            end else begin
               cmd.div_start = 1'b1;
               cmd.clear_row = 1'b1;
               state_in      = S_DIV;
            end
         end
         S_DIV: begin
            if (status.div_done)
               state_in = S_MULP;
         end
         S_MULP: begin
            cmd.mul_p = 1'b1;
            state_in  = S_MULD;
         end
         S_MULD: begin
            cmd.mul_d = 1'b1;
            state_in  = S_STEER;
         end
         S_STEER: begin
            if (status.out_free) begin
               cmd.load_steer = 1'b1;
               state_in       = S_ACCUM;
            end
         end
         default: state_in = S_ACCUM;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset)
         state_ff <= S_ACCUM;
      else
         state_ff <= state_in;
   end

endmodule

`default_nettype wire

FILE: rtl/core/line_position_pd_steer_core.sv
// pixels: one transfer per cycle while a row is being accumulated
// row end, hold or reverse: decide, then the result is loaded once the output register is free; input stalls meanwhile
// row end, steer or centred: decide, 18-step divider, done, multiply p, multiply d, steer, with input stalled
// at row end, input also stalls while an earlier result is still waiting at the output register
// reset: threshold 130, minimum count 20, accumulators and past error cleared, no result pending
`default_nettype none
`include "assert_macros.svh"

module line_position_pd_steer_core #(
   parameter int ROW_WIDTH = lpps_pkg::ROW_WIDTH_DEF
) (
   input  wire logic   clock,
   input  wire logic   reset,
   lpps_req_if.sink    req_bus,
   lpps_rsp_if.source  rsp_bus,
   lpps_csr_if.sink    csr_bus
);
   import lpps_pkg::*;

   lpps_cmd_type    cmd;
   lpps_status_type status;
   logic            req_ready;

   assign req_bus.ready = req_ready;
   assign csr_bus.ready = 1'b1;

   lpps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_last  (req_bus.last_in_row),
      .req_ready (req_ready),
      .cmd       (cmd),
      .status    (status)
   );

   lpps_dp #(
      .ROW_WIDTH (ROW_WIDTH)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .pixel      (req_bus.pixel),
      .csr_write  (csr_bus.valid),
      .csr_index  (csr_bus.index),
      .csr_data   (csr_bus.data),
      .rsp_ready  (rsp_bus.ready),
      .rsp_valid  (rsp_bus.valid),
      .rsp_action (rsp_bus.action),
      .rsp_left   (rsp_bus.left_motor_speed),
      .rsp_right  (rsp_bus.right_motor_speed)
   );

   `ASSERT_PROP(a_load_into_free_slot, clock, reset, (cmd.load_short || cmd.load_steer) |-> status.out_free, "result loaded over a pending transfer")
   `ASSERT_PROP(a_stall_after_row_end, clock, reset, (req_bus.valid && req_bus.ready && req_bus.last_in_row) |=> !req_bus.ready, "pixel taken right after row end")
   `ASSERT_PROP(a_stall_during_divide, clock, reset, cmd.div_start |=> (!req_bus.ready && !cmd.accum), "pixel taken while dividing")

endmodule

`default_nettype wire
